FILE: rtl/dtm_pkg.sv
// Package for the differential thruster mixer: shared types, codes and constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dtm_pkg;

   // Q2.14 fixed point: 1.0 is 16384
   localparam int ONE_Q14        = 16384;
   localparam int SPEED_W        = 16;
   localparam int DEADBAND_W     = 15;
   localparam int DEADBAND_RESET = 164;

   // Normalizing divider: quotient bits resolved one per cycle
   localparam int DIV_STEPS = 15;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ENABLED       = 2'd0,
      REG_MIX_NORMALIZE = 2'd1,
      REG_DEADBAND      = 2'd2
   } reg_idx_type;

   // Request kinds carried on tuser
   localparam logic REQ_FORWARD = 1'b0;
   localparam logic REQ_TURN    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIVIDE,
      ST_FIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  enabled;
      logic                  mix_normalize;
      logic [DEADBAND_W-1:0] deadband;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // store the clamped request speed
      logic calc;      // mix stored speeds, arm the divider
      logic step;      // one divider iteration
      logic fix;       // apply signs to the quotients
      logic out_load;  // move result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/dtm_csr.sv
// Configuration registers of the thruster mixer behind an APB-style port.
// Depends on dtm_pkg.
`default_nettype none

module dtm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dtm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dtm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dtm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output dtm_pkg::cfg_type                    cfg
);
   import dtm_pkg::*;

   logic                  enabled_ff, enabled_in;
   logic                  mix_normalize_ff, mix_normalize_in;
   logic [DEADBAND_W-1:0] deadband_ff, deadband_in;
   reg_idx_type           index;
   logic                  wr_en;

   assign index      = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes
   always_comb begin
      enabled_in       = enabled_ff;
      mix_normalize_in = mix_normalize_ff;
      deadband_in      = deadband_ff;
      if (wr_en) begin
         unique case (index)
            REG_ENABLED:       enabled_in       = csr_pwdata[0];
            REG_MIX_NORMALIZE: mix_normalize_in = csr_pwdata[0];
            REG_DEADBAND:      deadband_in      = csr_pwdata[DEADBAND_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff       <= 1'b1;
         mix_normalize_ff <= 1'b0;
         deadband_ff      <= DEADBAND_W'(DEADBAND_RESET);
      end else begin
         enabled_ff       <= enabled_in;
         mix_normalize_ff <= mix_normalize_in;
         deadband_ff      <= deadband_in;
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         REG_ENABLED:       csr_prdata = CSR_DATA_W'(enabled_ff);
         REG_MIX_NORMALIZE: csr_prdata = CSR_DATA_W'(mix_normalize_ff);
         REG_DEADBAND:      csr_prdata = CSR_DATA_W'(deadband_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.enabled       = enabled_ff;
   assign cfg.mix_normalize = mix_normalize_ff;
   assign cfg.deadband      = deadband_ff;

endmodule

`default_nettype wire

FILE: rtl/dtm_div_lane.sv
// One lane of the normalizing divider: |x| * 16384 / m, one quotient bit per cycle while step is high.
// Restoring division; needs |x| <= m. Depends on dtm_pkg.
`default_nettype none

module dtm_div_lane (
   input  wire logic                        clock,
   input  wire logic                        start,
   input  wire logic                        step,
   input  wire logic [dtm_pkg::SPEED_W-1:0] mag,
   input  wire logic [dtm_pkg::SPEED_W-1:0] divisor,
   output logic      [dtm_pkg::DIV_STEPS-1:0] quotient
);
   import dtm_pkg::*;

   logic [SPEED_W-1:0]   rem_ff;
   logic                 nbit_ff;
   logic [DIV_STEPS-1:0] quo_ff;
   logic [SPEED_W:0]     rem2;
   logic [SPEED_W:0]     diff;
   logic                 fits;

   // Dividend is mag << 14: the top bits seed the remainder, then mag[0], then zeros
   assign rem2 = {rem_ff, nbit_ff};
   assign diff = rem2 - {1'b0, divisor};
   assign fits = (rem2 >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, mag[SPEED_W-1:1]};
         nbit_ff <= mag[0];
         quo_ff  <= '0;
      end else if (step) begin
         rem_ff  <= fits ? diff[SPEED_W-1:0] : rem2[SPEED_W-1:0];
         nbit_ff <= 1'b0;
         quo_ff  <= {quo_ff[DIV_STEPS-2:0], fits};
      end
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/dtm_dpath.sv
// Datapath of the thruster mixer: stored speeds, mixing, two divider lanes,
// result and output registers. Depends on dtm_pkg and dtm_div_lane.
`default_nettype none

module dtm_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [dtm_pkg::SPEED_W-1:0] req_tdata,
   input  wire logic                        req_tuser,
   input  wire dtm_pkg::cfg_type            cfg,
   input  wire dtm_pkg::cmd_type            cmd,
   output dtm_pkg::status_type              status,
   output logic      [2*dtm_pkg::SPEED_W-1:0] rsp_tdata
);
   import dtm_pkg::*;

   localparam logic signed [SPEED_W-1:0] POS_ONE = SPEED_W'(ONE_Q14);
   localparam logic signed [SPEED_W-1:0] NEG_ONE = -SPEED_W'(ONE_Q14);
   localparam logic [SPEED_W-1:0]        MAG_ONE = SPEED_W'(ONE_Q14);

   logic signed [SPEED_W-1:0] forward_ff, turn_ff;
   logic signed [SPEED_W-1:0] res_left_ff, res_left_in;
   logic signed [SPEED_W-1:0] res_right_ff, res_right_in;
   logic [SPEED_W-1:0]        divisor_ff, divisor_in;
   logic                      sign_left_ff, sign_right_ff;
   logic [2*SPEED_W-1:0]      out_ff;

   logic signed [SPEED_W-1:0] speed_raw, speed_clamped;
   logic [SPEED_W-1:0]        abs_f, abs_t, deadband_ext;
   logic signed [SPEED_W:0]   sum, dif, half_sum, half_dif;
   logic [SPEED_W:0]          abs_sum17, abs_dif17;
   logic [SPEED_W-1:0]        abs_sum, abs_dif;
   logic                      need_div;
   logic [DIV_STEPS-1:0]      quo_left, quo_right;
   logic signed [SPEED_W-1:0] q_left, q_right;

   // Clamp the request speed to +/-1.0
   assign speed_raw = signed'(req_tdata);
   always_comb begin
      if (speed_raw > POS_ONE) begin
         speed_clamped = POS_ONE;
      end else if (speed_raw < NEG_ONE) begin
         speed_clamped = NEG_ONE;
      end else begin
         speed_clamped = speed_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_ff <= '0;
         turn_ff    <= '0;
      end else if (cmd.load) begin
         if (req_tuser == REQ_TURN) begin
            turn_ff <= speed_clamped;
         end else begin
            forward_ff <= speed_clamped;
         end
      end
   end

   // Magnitudes, sum and difference of the stored speeds
   assign abs_f        = forward_ff[SPEED_W-1] ? -forward_ff : forward_ff;
   assign abs_t        = turn_ff[SPEED_W-1] ? -turn_ff : turn_ff;
   assign deadband_ext = {1'b0, cfg.deadband};
   assign sum          = {forward_ff[SPEED_W-1], forward_ff} + {turn_ff[SPEED_W-1], turn_ff};
   assign dif          = {forward_ff[SPEED_W-1], forward_ff} - {turn_ff[SPEED_W-1], turn_ff};
   assign abs_sum17    = sum[SPEED_W] ? -sum : sum;
   assign abs_dif17    = dif[SPEED_W] ? -dif : dif;
   assign abs_sum      = abs_sum17[SPEED_W-1:0];
   assign abs_dif      = abs_dif17[SPEED_W-1:0];
   // halving, truncated toward zero
   assign half_sum     = (sum + (SPEED_W+1)'(sum[SPEED_W])) >>> 1;
   assign half_dif     = (dif + (SPEED_W+1)'(dif[SPEED_W])) >>> 1;

   // Mode selection
   always_comb begin
      need_div     = 1'b0;
      divisor_in   = divisor_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      if (cmd.calc) begin
         priority if (abs_f < deadband_ext) begin
            res_left_in  = turn_ff;
            res_right_in = -turn_ff;
         end else if (abs_t < deadband_ext) begin
            res_left_in  = forward_ff;
            res_right_in = forward_ff;
         end else if (!cfg.mix_normalize) begin
            res_left_in  = half_sum[SPEED_W-1:0];
            res_right_in = half_dif[SPEED_W-1:0];
         end else if (abs_sum > MAG_ONE && abs_sum > abs_dif) begin
            need_div   = 1'b1;
            divisor_in = abs_sum;
         end else if (abs_dif > MAG_ONE) begin
            need_div   = 1'b1;
            divisor_in = abs_dif;
         end else begin
            res_left_in  = sum[SPEED_W-1:0];
            res_right_in = dif[SPEED_W-1:0];
         end
      end else if (cmd.fix) begin
         res_left_in  = sign_left_ff ? -q_left : q_left;
         res_right_in = sign_right_ff ? -q_right : q_right;
      end
   end

   assign status.need_div = need_div;

   always_ff @(posedge clock) begin
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      divisor_ff   <= divisor_in;
      if (cmd.calc) begin
         sign_left_ff  <= sum[SPEED_W];
         sign_right_ff <= dif[SPEED_W];
      end
   end

   // Two divider lanes share the divisor
   dtm_div_lane u_div_left (
      .clock    (clock),
      .start    (cmd.calc),
      .step     (cmd.step),
      .mag      (abs_sum),
      .divisor  (divisor_ff),
      .quotient (quo_left)
   );

   dtm_div_lane u_div_right (
      .clock    (clock),
      .start    (cmd.calc),
      .step     (cmd.step),
      .mag      (abs_dif),
      .divisor  (divisor_ff),
      .quotient (quo_right)
   );

   assign q_left  = signed'(SPEED_W'(quo_left));
   assign q_right = signed'(SPEED_W'(quo_right));

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= {res_right_ff, res_left_ff};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

`default_nettype wire

FILE: rtl/dtm_ctrl.sv
// Controller of the thruster mixer: sequences mixing and division and owns
// both handshakes. Depends on dtm_pkg.
`default_nettype none

module dtm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic                enabled,
   input  wire dtm_pkg::status_type status,
   output dtm_pkg::cmd_type         cmd
);
   import dtm_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            // a request taken while disabled is dropped
            if (req_tvalid && enabled) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            count_in = '0;
            state_in = status.need_div ? ST_DIVIDE : ST_DONE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/differential_thruster_mixer_unit.sv
// Differential thruster mixer, top level: a speed request (forward or turn, Q2.14)
// is clamped to +/-1.0, stored, and the stored pair is mixed into one left/right
// result. From acceptance, a request passes the calculate and done states when no
// normalization is needed, and calculate, divide, fix and done when normalizing mode
// scales the sides; the scaling is a restoring divider that resolves one quotient bit
// per cycle. Requests are taken one at a time; a result waiting in the output
// register does not hold off the next request. While disabled, requests are
// taken and dropped without a result. Depends on dtm_pkg, dtm_csr, dtm_ctrl,
// dtm_dpath and dtm_div_lane.
`default_nettype none

module differential_thruster_mixer_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [dtm_pkg::SPEED_W-1:0]    req_tdata,   // [15:0] speed_value
   input  wire logic                           req_tuser,   // [0] req_type
   // response channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [2*dtm_pkg::SPEED_W-1:0]  rsp_tdata,   // [15:0] left_speed, [31:16] right_speed
   // configuration
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dtm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dtm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dtm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import dtm_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   dtm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .enabled    (cfg.enabled),
      .status     (status),
      .cmd        (cmd)
   );

   dtm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: rtl/dtm_checker.sv
// Port-level checks for the thruster mixer, bound to the top level.
// Depends on dtm_pkg and differential_thruster_mixer_unit.
`default_nettype none

module dtm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [2*dtm_pkg::SPEED_W-1:0]  rsp_tdata,
   input wire logic                           csr_pready
);
   import dtm_pkg::*;

   localparam logic signed [SPEED_W-1:0] POS_ONE = SPEED_W'(ONE_Q14);
   localparam logic signed [SPEED_W-1:0] NEG_ONE = -SPEED_W'(ONE_Q14);

   // a stalled response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no response pending right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // both thruster speeds stay within +/-1.0
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (signed'(rsp_tdata[SPEED_W-1:0]) <= POS_ONE)
                  && (signed'(rsp_tdata[SPEED_W-1:0]) >= NEG_ONE)
                  && (signed'(rsp_tdata[2*SPEED_W-1:SPEED_W]) <= POS_ONE)
                  && (signed'(rsp_tdata[2*SPEED_W-1:SPEED_W]) >= NEG_ONE))
      else $error("thruster speed out of range");

   // a new response comes out as the block goes back to taking requests
   a_rsp_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("response raised while a request is still in work");

   // configuration port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind differential_thruster_mixer_unit dtm_checker u_dtm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

`default_nettype wire

FILE: sim/differential_thruster_mixer_unit_test.sv
// Self-checking testbench for differential_thruster_mixer_unit: speed requests
// are mixed by a local predictor and compared with every response, field by field.
// Depends on dtm_pkg and the differential_thruster_mixer_unit RTL.
`timescale 1ns / 100ps

module differential_thruster_mixer_unit_test;
   import dtm_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 40;        // longer than a normalizing request takes
   localparam int TARGET_CMDS   = 1700;      // requests taken while enabled
   localparam int LIMIT_CYCLES  = 1_200_000;
   localparam int MAX_REPORTS   = 10;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ENABLED   = {REG_ENABLED, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_NORMALIZE = {REG_MIX_NORMALIZE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_DEADBAND  = {REG_DEADBAND, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED  = 4'hC;   // register index 3, unused

   typedef struct packed {
      logic                      kind;
      logic signed [SPEED_W-1:0] speed;
   } speed_cmd_type;

   // right in the upper half, left in the lower half, as on rsp_tdata
   typedef struct packed {
      logic [SPEED_W-1:0] right;
      logic [SPEED_W-1:0] left;
   } thrust_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [SPEED_W-1:0]         req_tdata  = '0;   // [15:0] speed_value
   logic                       req_tuser  = 1'b0; // [0] req_type
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [2*SPEED_W-1:0]       rsp_tdata;         // [15:0] left_speed, [31:16] right_speed
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   differential_thruster_mixer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Shadow of the block: registers and stored speeds
   logic cfg_en       = 1'b1;
   logic cfg_norm     = 1'b0;
   int   cfg_deadband = DEADBAND_RESET;
   int   fwd_q14      = 0;
   int   turn_q14     = 0;

   speed_cmd_type   speed_cmd_q[$];
   thrust_pair_type thrust_expect_q[$];
   speed_cmd_type   drv_cmd;
   thrust_pair_type got_pair;
   thrust_pair_type want_pair;
   int              send_gap       = 0;
   int              rsp_stall      = 0;
   int              mismatch_count = 0;
   int              enabled_cmds   = 0;
   bit              steady_flow    = 1'b0;

   function automatic int mag(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // x * 1.0 / m, truncated toward zero
   function automatic int scale_q14(input int x, input int m);
      return (x * ONE_Q14) / m;
   endfunction

   // Store one request speed and queue the mixed left/right pair it yields
   function automatic void mix_thrusters(input logic kind, input logic signed [SPEED_W-1:0] raw);
      int v;
      int l;
      int r;
      int al;
      int ar;
      thrust_pair_type pair;
      if (!cfg_en) return;
      v = raw;
      if (v > ONE_Q14) v = ONE_Q14;
      if (v < -ONE_Q14) v = -ONE_Q14;
      if (kind == REQ_TURN) turn_q14 = v;
      else fwd_q14 = v;

      if (mag(fwd_q14) < cfg_deadband) begin
         l = turn_q14;
         r = -turn_q14;
      end else if (mag(turn_q14) < cfg_deadband) begin
         l = fwd_q14;
         r = fwd_q14;
      end else if (!cfg_norm) begin
         l = (fwd_q14 + turn_q14) / 2;
         r = (fwd_q14 - turn_q14) / 2;
      end else begin
         l  = fwd_q14 + turn_q14;
         r  = fwd_q14 - turn_q14;
         al = mag(l);
         ar = mag(r);
         if (al > ONE_Q14 && al > ar) begin
            l = scale_q14(l, al);
            r = scale_q14(r, al);
         end else if (ar > ONE_Q14) begin
            l = scale_q14(l, ar);
            r = scale_q14(r, ar);
         end
      end
      pair.left  = l[SPEED_W-1:0];
      pair.right = r[SPEED_W-1:0];
      thrust_expect_q.push_back(pair);
   endfunction

   // Gap length: mostly none or short, now and then long
   function automatic int idle_len();
      int pick;
      if (steady_flow) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [SPEED_W-1:0] rand_speed(input int db);
      int v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: v = -32768;
               1: v = 32767;
               2: v = ONE_Q14;
               3: v = -ONE_Q14;
               4: v = ONE_Q14 + 1;
               default: v = -ONE_Q14 - 1;
            endcase
         end
         1: begin
            // straddle the deadband edge
            v = db + $urandom_range(0, 3) - 2;
            if ($urandom_range(0, 1)) v = -v;
         end
         2: v = $urandom_range(0, 600) - 300;
         3, 4, 5: v = $urandom();
         default: v = $urandom_range(0, 2 * ONE_Q14) - ONE_Q14;
      endcase
      return v[SPEED_W-1:0];
   endfunction

   function automatic void queue_cmd(input logic kind, input int speed);
      speed_cmd_type c;
      c.kind  = kind;
      c.speed = speed[SPEED_W-1:0];
      speed_cmd_q.push_back(c);
      if (cfg_en) enabled_cmds++;
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) mix_thrusters(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (speed_cmd_q.size() != 0) begin
               drv_cmd = speed_cmd_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= drv_cmd.kind;
               req_tdata  <= drv_cmd.speed;
               send_gap = idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_pair = rsp_tdata;
            if (thrust_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response with none pending: left %0d right %0d", $realtime,
                           $signed(got_pair.left), $signed(got_pair.right));
            end else begin
               want_pair = thrust_expect_q.pop_front();
               if (got_pair.left !== want_pair.left || got_pair.right !== want_pair.right) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: mismatch: left exp %0d got %0d, right exp %0d got %0d",
                              $realtime, $signed(want_pair.left), $signed(got_pair.left),
                              $signed(want_pair.right), $signed(got_pair.right));
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) rsp_stall = idle_len();
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         ADDR_ENABLED:   cfg_en = value[0];
         ADDR_NORMALIZE: cfg_norm = value[0];
         ADDR_DEADBAND:  cfg_deadband = value[DEADBAND_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic en, input logic norm, input int db);
      csr_write(ADDR_ENABLED, {31'b0, en});
      csr_write(ADDR_NORMALIZE, {31'b0, norm});
      csr_write(ADDR_DEADBAND, db);
   endtask

   // Hold off until every request is taken and every response is back
   task automatic wait_idle();
      do @(negedge clock);
      while (speed_cmd_q.size() != 0 || req_tvalid || thrust_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Stimulus and end of run
   initial begin
      logic en;
      logic norm;
      int   db;
      int   count;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // An unmapped register index must change nothing
      csr_write(ADDR_UNMAPPED, 32'h0);

      // Halving mode at reset settings: saturation, deadband edges, truncation
      queue_cmd(REQ_FORWARD, 32767);
      queue_cmd(REQ_TURN, -32768);
      queue_cmd(REQ_FORWARD, ONE_Q14 + 1);
      queue_cmd(REQ_TURN, -ONE_Q14 - 1);
      queue_cmd(REQ_FORWARD, 163);
      queue_cmd(REQ_FORWARD, -164);
      queue_cmd(REQ_TURN, 163);
      queue_cmd(REQ_TURN, -1);
      queue_cmd(REQ_FORWARD, 0);
      queue_cmd(REQ_TURN, ONE_Q14);
      queue_cmd(REQ_FORWARD, -ONE_Q14);
      queue_cmd(REQ_FORWARD, 301);
      queue_cmd(REQ_TURN, -1000);
      wait_idle();

      // Normalizing mode with no deadband
      configure(1'b1, 1'b1, 0);
      queue_cmd(REQ_FORWARD, ONE_Q14);
      queue_cmd(REQ_TURN, ONE_Q14);
      queue_cmd(REQ_TURN, -ONE_Q14);
      queue_cmd(REQ_FORWARD, -12000);
      queue_cmd(REQ_TURN, 12000);
      queue_cmd(REQ_TURN, 5000);
      queue_cmd(REQ_FORWARD, 32767);
      queue_cmd(REQ_FORWARD, 0);
      wait_idle();

      // Disabled: requests dropped, stored speeds untouched
      configure(1'b0, 1'b0, DEADBAND_RESET);
      queue_cmd(REQ_FORWARD, -9000);
      queue_cmd(REQ_TURN, 7000);
      wait_idle();

      // Deadband above 1.0: every forward speed counts as zero
      configure(1'b1, 1'b0, 32767);
      queue_cmd(REQ_FORWARD, ONE_Q14);
      queue_cmd(REQ_TURN, 4321);
      wait_idle();

      // Random phases, each with its own settings
      while (enabled_cmds < TARGET_CMDS) begin
         en   = ($urandom_range(0, 9) != 0);
         norm = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 7))
            0: db = 0;
            1: db = ONE_Q14;
            2: db = 32767;
            3: db = ONE_Q14 + 1;
            4: db = $urandom_range(0, 32767);
            default: db = $urandom_range(0, 2000);
         endcase
         configure(en, norm, db);
         steady_flow = ($urandom_range(0, 3) == 0);
         count = en ? $urandom_range(20, 120) : $urandom_range(5, 15);
         repeat (count) queue_cmd(1'($urandom_range(0, 1)), $signed(rand_speed(db)));
         wait_idle();
      end

      if (mismatch_count == 0 && thrust_expect_q.size() == 0)
         $display("differential_thruster_mixer_unit verification clean");
      else
         $display("differential_thruster_mixer_unit verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("differential_thruster_mixer_unit verification failed");
      $finish;
   end

endmodule
